>>> rtl/mtg_pkg.sv
// Package for the multi-tap gesture detector.
// Holds the item, state, result and configuration types and the code constants.
// No dependencies; every other file but mtg_if imports it.
package mtg_pkg;

    typedef enum logic [1:0] {
        KIND_BEGAN     = 2'd0,
        KIND_MOVED     = 2'd1,
        KIND_ENDED     = 2'd2,
        KIND_CANCELLED = 2'd3
    } t_kind;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUIRED_TAPS  = 3'd0,
        CFG_TAP_GAP_TIME   = 3'd1,
        CFG_PRESS_TIME     = 3'd2,
        CFG_TAP_GAP_DIST   = 3'd3,
        CFG_PRESS_DIST     = 3'd4
    } t_cfg_reg;

    localparam logic [3:0]  RST_REQUIRED_TAPS = 4'd1;
    localparam logic [15:0] RST_TAP_GAP_TIME  = 16'd750;
    localparam logic [15:0] RST_PRESS_TIME    = 16'd250;
    // Distance limits are kept squared; reset values are 20*20 and 10*10.
    localparam logic [23:0] RST_TAP_GAP_DSQ   = 24'd400;
    localparam logic [23:0] RST_PRESS_DSQ     = 24'd100;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [3:0]         touch_count;
        logic signed [15:0] touch_x;
        logic signed [15:0] touch_y;
        logic [31:0]        time_ms;
    } t_in_item;

    typedef struct packed {
        logic               gesture;
        logic signed [15:0] tap_x;
        logic signed [15:0] tap_y;
    } t_res_item;

    typedef struct packed {
        logic [3:0]         tap_count;
        logic               stored_valid;
        logic signed [15:0] stored_x;
        logic signed [15:0] stored_y;
        logic [31:0]        stored_time;
    } t_state;

    typedef struct packed {
        logic [3:0]  required_taps;
        logic [15:0] tap_gap_timeout_ms;
        logic [15:0] press_timeout_ms;
        logic [23:0] tap_gap_dist_sq;
        logic [23:0] press_dist_sq;
    } t_cfg;

endpackage

>>> rtl/mtg_if.sv
// Valid/ready channel interfaces for the touch event and tap result items.
// Depends on nothing; the payload fields follow the block's item formats.
interface mtg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [3:0]         touch_count;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic [31:0]        time_ms;

    modport source (output valid, event_kind, touch_count, touch_x, touch_y, time_ms,
                    input ready);
    modport sink   (input valid, event_kind, touch_count, touch_x, touch_y, time_ms,
                    output ready);
endinterface

interface mtg_out_if;
    logic               valid;
    logic               ready;
    logic               gesture;
    logic signed [15:0] tap_x;
    logic signed [15:0] tap_y;

    modport source (output valid, gesture, tap_x, tap_y, input ready);
    modport sink   (input valid, gesture, tap_x, tap_y, output ready);
endinterface

>>> rtl/mtg_cfg.sv
// Configuration register bank of the multi-tap gesture detector.
// Depends on mtg_pkg; distance limits are squared when written.
module mtg_cfg
    import mtg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg        r_cfg;
    logic [23:0] n_dist_sq;

    // Squaring at write time keeps the multiplier off the item path.
    assign n_dist_sq = i_cfg_data[11:0] * i_cfg_data[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.required_taps      <= RST_REQUIRED_TAPS;
            r_cfg.tap_gap_timeout_ms <= RST_TAP_GAP_TIME;
            r_cfg.press_timeout_ms   <= RST_PRESS_TIME;
            r_cfg.tap_gap_dist_sq    <= RST_TAP_GAP_DSQ;
            r_cfg.press_dist_sq      <= RST_PRESS_DSQ;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_REQUIRED_TAPS: r_cfg.required_taps      <= i_cfg_data[3:0];
                CFG_TAP_GAP_TIME:  r_cfg.tap_gap_timeout_ms <= i_cfg_data;
                CFG_PRESS_TIME:    r_cfg.press_timeout_ms   <= i_cfg_data;
                CFG_TAP_GAP_DIST:  r_cfg.tap_gap_dist_sq    <= n_dist_sq;
                CFG_PRESS_DIST:    r_cfg.press_dist_sq      <= n_dist_sq;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/mtg_eval.sv
// Single-pass evaluation of one touch event against the tap state.
// Depends on mtg_pkg; purely combinational, the caller registers the results.
module mtg_eval
    import mtg_pkg::*;
(
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_res_item o_res
);

    logic [31:0]        time_diff;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [34:0]        dist_sq;
    logic               gap_ok;
    logic               press_ok;
    logic               several;
    logic [3:0]         cnt_inc;

    assign time_diff = i_item.time_ms - i_state.stored_time;
    assign dx = {i_item.touch_x[15], i_item.touch_x} - {i_state.stored_x[15], i_state.stored_x};
    assign dy = {i_item.touch_y[15], i_item.touch_y} - {i_state.stored_y[15], i_state.stored_y};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign dist_sq = {1'b0, $unsigned(dx_sq)} + {1'b0, $unsigned(dy_sq)};

    assign gap_ok   = (time_diff < {16'd0, i_cfg.tap_gap_timeout_ms})
                   && (dist_sq < {11'd0, i_cfg.tap_gap_dist_sq});
    assign press_ok = (time_diff < {16'd0, i_cfg.press_timeout_ms})
                   && (dist_sq < {11'd0, i_cfg.press_dist_sq});

    assign several = i_item.touch_count > 4'd1;
    assign cnt_inc = i_state.tap_count + 4'd1;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (several) begin
            o_state.tap_count    = '0;
            o_state.stored_valid = 1'b0;
        end else begin
            case (t_kind'(i_item.event_kind))
                KIND_CANCELLED: begin
                    o_state.tap_count    = '0;
                    o_state.stored_valid = 1'b0;
                end
                KIND_BEGAN: begin
                    // A late or distant press starts a new sequence.
                    if (i_state.tap_count != 4'd0 && !gap_ok) begin
                        o_state.tap_count = '0;
                    end
                    o_state.stored_valid = 1'b1;
                    o_state.stored_x     = i_item.touch_x;
                    o_state.stored_y     = i_item.touch_y;
                    o_state.stored_time  = i_item.time_ms;
                end
                KIND_ENDED: begin
                    if (i_state.stored_valid && press_ok) begin
                        o_state.tap_count   = cnt_inc;
                        o_state.stored_x    = i_item.touch_x;
                        o_state.stored_y    = i_item.touch_y;
                        o_state.stored_time = i_item.time_ms;
                        if (cnt_inc == i_cfg.required_taps) begin
                            o_state.tap_count    = '0;
                            o_state.stored_valid = 1'b0;
                            o_res.gesture        = 1'b1;
                            o_res.tap_x          = i_item.touch_x;
                            o_res.tap_y          = i_item.touch_y;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/multi_tap_gesture_detector.sv
// Top level of the multi-tap gesture detector.
// Depends on mtg_pkg, mtg_if, mtg_cfg and mtg_eval.
//
// Each touch event item yields exactly one result item: gesture is 1 with the
// release position when the configured number of close taps completes, and 0
// with zero positions otherwise. An accepted item sits in an input register,
// is evaluated against the tap state combinationally, and its result lands in
// an output register when that register is free or drains; the result is
// presented from the output register and holds there until it is taken. One
// item per clock is sustained while results are taken. The per-cycle path is
// the position difference, two 17x17 squarings, a 35-bit add and the limit
// compares. Distance limits are squared as they are written. Configuration
// writes are one per clock with no read-back and belong to idle periods.
module multi_tap_gesture_detector
    import mtg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mtg_in_if.sink                i_in,
    mtg_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_state    r_state;
    t_state    n_state;
    t_res_item n_res;
    t_res_item r_res;
    logic      r_out_valid;
    logic      advance;
    logic      in_ready;
    logic      in_take;

    mtg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mtg_eval u_eval (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // The held item moves on whenever the output register is free or drains.
    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign in_take  = i_in.valid && in_ready;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.gesture = r_res.gesture;
    assign o_out.tap_x   = r_res.tap_x;
    assign o_out.tap_y   = r_res.tap_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.event_kind  <= i_in.event_kind;
            r_in.touch_count <= i_in.touch_count;
            r_in.touch_x     <= i_in.touch_x;
            r_in.touch_y     <= i_in.touch_y;
            r_in.time_ms     <= i_in.time_ms;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // A pending tap count always has a stored event behind it.
    a_count_needs_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tap_count != 4'd0 |-> r_state.stored_valid)
        else $error("tap count pending without a stored event");

    // Firing an action always leaves the sequence cleared.
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.gesture |=> r_state.tap_count == 4'd0 && !r_state.stored_valid)
        else $error("state not cleared after an action");

    // Results without an action carry zero positions.
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.gesture |-> r_res.tap_x == 16'sd0 && r_res.tap_y == 16'sd0)
        else $error("nonzero position on a result without an action");

    // The evaluated state changes only when an item passes to the output.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state.tap_count) && $stable(r_state.stored_valid))
        else $error("tap state changed without an item");

endmodule

>>> dv/multi_tap_gesture_detector_test.sv
// Self-checking testbench for the multi-tap gesture detector.
// Drives touch event items and checks every tap result against a local tap tracker or a directed row.
// Depends on mtg_pkg, the channel interfaces in mtg_if and the detector top level.
`timescale 1ns / 100ps

module multi_tap_gesture_detector_test;
    import mtg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 60;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        t_in_item  ev;
        bit        typed;
        t_res_item want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mtg_in_if  touch_ch ();
    mtg_out_if tap_ch ();

    multi_tap_gesture_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (touch_ch),
        .o_out      (tap_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Settings as the tracker sees them.
    logic [3:0]  taps_needed;
    logic [15:0] gap_time_lim;
    logic [15:0] press_time_lim;
    logic [11:0] gap_dist_lim;
    logic [11:0] press_dist_lim;

    // Tap state as the tracker sees it.
    logic [3:0]         taps_so_far;
    logic               press_held;
    logic signed [15:0] held_x;
    logic signed [15:0] held_y;
    logic [31:0]        held_stamp;

    t_res_item tap_results_due [$];
    t_row      directed_rows [$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int gestures     = 0;
    int settings_run = 1;
    int cycle_count  = 0;

    function automatic bit near_in_time(logic [31:0] stamp, logic [15:0] lim);
        logic [31:0] diff;
        diff = stamp - held_stamp;
        return diff < {16'd0, lim};
    endfunction

    function automatic bit near_in_place(logic signed [15:0] x, logic signed [15:0] y,
                                         logic [11:0] lim);
        longint dx;
        longint dy;
        longint unsigned dist_sq;
        longint unsigned lim_sq;
        dx      = longint'(x) - longint'(held_x);
        dy      = longint'(y) - longint'(held_y);
        dist_sq = longint'(dx * dx + dy * dy);
        lim_sq  = longint'(lim) * longint'(lim);
        return dist_sq < lim_sq;
    endfunction

    function automatic void forget_taps();
        taps_so_far = 4'd0;
        press_held  = 1'b0;
    endfunction

    // Advances the tap state by one touch event and returns the result it causes.
    function automatic t_res_item track_touch(t_in_item ev);
        t_res_item r;
        r = '0;
        if (ev.touch_count > 4'd1 || ev.event_kind == KIND_CANCELLED) begin
            forget_taps();
        end else if (ev.event_kind == KIND_BEGAN) begin
            if (taps_so_far != 4'd0 &&
                (!near_in_time(ev.time_ms, gap_time_lim) ||
                 !near_in_place(ev.touch_x, ev.touch_y, gap_dist_lim))) begin
                forget_taps();
            end
            press_held = 1'b1;
            held_x     = ev.touch_x;
            held_y     = ev.touch_y;
            held_stamp = ev.time_ms;
        end else if (ev.event_kind == KIND_ENDED && press_held) begin
            if (near_in_time(ev.time_ms, press_time_lim) &&
                near_in_place(ev.touch_x, ev.touch_y, press_dist_lim)) begin
                taps_so_far = taps_so_far + 4'd1;
                held_x      = ev.touch_x;
                held_y      = ev.touch_y;
                held_stamp  = ev.time_ms;
                if (taps_so_far == taps_needed) begin
                    forget_taps();
                    r.gesture = 1'b1;
                    r.tap_x   = ev.touch_x;
                    r.tap_y   = ev.touch_y;
                end
            end
        end
        return r;
    endfunction

    function automatic void add_row(t_kind kind, logic [3:0] count, int x, int y,
                                    logic [31:0] stamp, bit typed = 1'b0,
                                    bit g = 1'b0, int wx = 0, int wy = 0);
        t_row row;
        row.ev.event_kind  = kind;
        row.ev.touch_count = count;
        row.ev.touch_x     = x[15:0];
        row.ev.touch_y     = y[15:0];
        row.ev.time_ms     = stamp;
        row.typed          = typed;
        row.want.gesture   = g;
        row.want.tap_x     = wx[15:0];
        row.want.tap_y     = wy[15:0];
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
        errors++;
    endtask

    // Offers one item after a random gap; the expected result is queued once it is taken.
    task automatic send_item(t_in_item ev, bit typed = 1'b0, t_res_item want = '0);
        int gap;
        t_res_item due;
        gap = pick_gap();
        if (gap > 0) begin
            touch_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        touch_ch.valid       <= 1'b1;
        touch_ch.event_kind  <= ev.event_kind;
        touch_ch.touch_count <= ev.touch_count;
        touch_ch.touch_x     <= ev.touch_x;
        touch_ch.touch_y     <= ev.touch_y;
        touch_ch.time_ms     <= ev.time_ms;
        @(posedge i_clk);
        while (!touch_ch.ready) @(posedge i_clk);
        due = track_touch(ev);
        tap_results_due.push_back(typed ? want : due);
        items_sent++;
    endtask

    task automatic settle(int cycles);
        touch_ch.valid <= 1'b0;
        while (tap_results_due.size() != 0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_REQUIRED_TAPS: taps_needed    = value[3:0];
            CFG_TAP_GAP_TIME:  gap_time_lim   = value;
            CFG_PRESS_TIME:    press_time_lim = value;
            CFG_TAP_GAP_DIST:  gap_dist_lim   = value[11:0];
            CFG_PRESS_DIST:    press_dist_lim = value[11:0];
            default: ;
        endcase
    endtask

    task automatic write_config(logic [3:0] need, logic [15:0] gap_t, logic [15:0] press_t,
                                logic [11:0] gap_d, logic [11:0] press_d);
        settle(4);
        write_reg(CFG_REQUIRED_TAPS, {12'd0, need});
        write_reg(CFG_TAP_GAP_TIME, gap_t);
        write_reg(CFG_PRESS_TIME, press_t);
        write_reg(CFG_TAP_GAP_DIST, {4'd0, gap_d});
        write_reg(CFG_PRESS_DIST, {4'd0, press_d});
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic t_in_item noise_item();
        t_in_item ev;
        ev.event_kind  = 2'($urandom_range(0, 3));
        ev.touch_count = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15)) : 4'd1;
        ev.touch_x     = 16'($urandom);
        ev.touch_y     = 16'($urandom);
        ev.time_ms     = $urandom;
        return ev;
    endfunction

    // Moves a position inside half the limit per axis, or past the limit when spread.
    function automatic logic signed [15:0] nudge(logic signed [15:0] p, int lim, bit spread);
        int off;
        int v;
        if (spread) begin
            off = lim + $urandom_range(0, lim + 1);
            if ($urandom_range(0, 1) != 0) off = -off;
        end else begin
            off = $urandom_range(0, 2 * (lim / 2)) - lim / 2;
        end
        v = p + off;
        return v[15:0];
    endfunction

    function automatic logic [31:0] later(logic [31:0] stamp, int lim, bit late);
        if (late) return stamp + lim + $urandom_range(0, 2000);
        if (lim == 0) return stamp;
        return stamp + $urandom_range(0, lim - 1);
    endfunction

    // A run of press/release pairs meant to count as taps; a dirty run breaks some of them.
    task automatic send_tap_chain(int n, bit clean);
        t_in_item ev;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0] stamp;
        bit bad;
        bit on_time;
        x     = 16'($urandom);
        y     = 16'($urandom);
        stamp = $urandom;
        for (int i = 0; i < n; i++) begin
            if (!clean && $urandom_range(0, 9) == 0) send_item(noise_item());
            bad     = !clean && $urandom_range(0, 3) == 0;
            on_time = $urandom_range(0, 1) != 0;
            if (i > 0) begin
                x     = nudge(x, int'(gap_dist_lim), bad && on_time);
                y     = nudge(y, int'(gap_dist_lim), bad && on_time);
                stamp = later(stamp, int'(gap_time_lim), bad && !on_time);
            end
            ev.event_kind  = KIND_BEGAN;
            ev.touch_count = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'd1;
            ev.touch_x     = x;
            ev.touch_y     = y;
            ev.time_ms     = stamp;
            send_item(ev);
            if ($urandom_range(0, 7) == 0) begin
                ev.event_kind = KIND_MOVED;
                ev.touch_x    = 16'($urandom);
                ev.touch_y    = 16'($urandom);
                send_item(ev);
            end
            bad     = !clean && $urandom_range(0, 3) == 0;
            on_time = $urandom_range(0, 1) != 0;
            x       = nudge(x, int'(press_dist_lim), bad && on_time);
            y       = nudge(y, int'(press_dist_lim), bad && on_time);
            stamp   = later(stamp, int'(press_time_lim), bad && !on_time);
            ev.event_kind  = KIND_ENDED;
            ev.touch_count = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'd1;
            ev.touch_x     = x;
            ev.touch_y     = y;
            ev.time_ms     = stamp;
            send_item(ev);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, tap_results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: checks every taken item and paces ready, with one long hold-off.
    initial begin
        int  stall_left;
        int  run_left;
        int  hold_left;
        bit  hold_done;
        bit  nxt_ready;
        int  r;
        t_res_item want;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        tap_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (tap_ch.valid && tap_ch.ready) begin
                if (tap_results_due.size() == 0) begin
                    $display("UNEXPECTED result %0d: gesture %0d at (%0d, %0d)", results_seen,
                             tap_ch.gesture, tap_ch.tap_x, tap_ch.tap_y);
                    errors++;
                end else begin
                    want = tap_results_due.pop_front();
                    if (tap_ch.gesture !== want.gesture)
                        report_mismatch("gesture", int'(tap_ch.gesture), int'(want.gesture));
                    if (tap_ch.tap_x !== want.tap_x)
                        report_mismatch("tap_x", int'(tap_ch.tap_x), int'(want.tap_x));
                    if (tap_ch.tap_y !== want.tap_y)
                        report_mismatch("tap_y", int'(tap_ch.tap_y), int'(want.tap_y));
                    if (want.gesture) gestures++;
                end
                results_seen++;
            end
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) stall_left = $urandom_range(1, 3);
                    else if (r < 23) stall_left = $urandom_range(15, 50);
                    else run_left = $urandom_range(1, 40);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_ready = 1'b0;
                end else begin
                    run_left--;
                    nxt_ready = 1'b1;
                end
            end
            tap_ch.ready <= nxt_ready;
            @(posedge i_clk);
        end
    end

    initial begin
        int phase_end;
        int target;
        logic [3:0] need;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_REQUIRED_TAPS;
        cfg_data             <= '0;
        touch_ch.valid       <= 1'b0;
        touch_ch.event_kind  <= KIND_MOVED;
        touch_ch.touch_count <= 4'd1;
        touch_ch.touch_x     <= '0;
        touch_ch.touch_y     <= '0;
        touch_ch.time_ms     <= '0;

        taps_needed    = RST_REQUIRED_TAPS;
        gap_time_lim   = RST_TAP_GAP_TIME;
        press_time_lim = RST_PRESS_TIME;
        gap_dist_lim   = 12'd20;
        press_dist_lim = 12'd10;
        taps_so_far    = 4'd0;
        press_held     = 1'b0;
        held_x         = '0;
        held_y         = '0;
        held_stamp     = '0;

        // Reset settings: one tap fires, 250 ms and 10 pixels per press.
        add_row(KIND_ENDED, 4'd1, 5, 5, 32'd10, 1'b1);      // release with nothing held
        add_row(KIND_BEGAN, 4'd1, 0, 0, 32'd100, 1'b1);
        add_row(KIND_ENDED, 4'd1, 3, 4, 32'd200, 1'b1, 1'b1, 3, 4);
        add_row(KIND_BEGAN, 4'd1, -32768, -32768, 32'd1000, 1'b1);
        add_row(KIND_ENDED, 4'd1, -32768, -32768, 32'd1249, 1'b1, 1'b1, -32768, -32768);
        // The timestamp wraps between press and release.
        add_row(KIND_BEGAN, 4'd1, 32767, 32767, 32'hFFFF_FFF0, 1'b1);
        add_row(KIND_ENDED, 4'd1, 32767, 32767, 32'h0000_0010, 1'b1, 1'b1, 32767, 32767);
        add_row(KIND_BEGAN, 4'd1, 100, 100, 32'd3000);
        add_row(KIND_ENDED, 4'd1, 110, 100, 32'd3010);      // exactly at the distance limit
        add_row(KIND_ENDED, 4'd1, 100, 100, 32'd3250);      // exactly at the time limit
        add_row(KIND_MOVED, 4'd1, 100, 100, 32'd3100, 1'b1);
        add_row(KIND_ENDED, 4'd1, 109, 100, 32'd3249);
        add_row(KIND_BEGAN, 4'd0, 50, 50, 32'd4000, 1'b1);
        add_row(KIND_ENDED, 4'd0, 50, 50, 32'd4001, 1'b1, 1'b1, 50, 50);
        add_row(KIND_BEGAN, 4'd1, 0, 0, 32'd5000, 1'b1);
        add_row(KIND_BEGAN, 4'd15, 0, 0, 32'd5000, 1'b1);   // several touches clear
        add_row(KIND_ENDED, 4'd1, 0, 0, 32'd5001, 1'b1);
        add_row(KIND_BEGAN, 4'd1, 7, 7, 32'd6000, 1'b1);
        add_row(KIND_CANCELLED, 4'd1, 7, 7, 32'd6001, 1'b1);
        add_row(KIND_ENDED, 4'd1, 7, 7, 32'd6002, 1'b1);
        add_row(KIND_BEGAN, 4'd2, -1, -1, 32'hFFFF_FFFF, 1'b1);
        add_row(KIND_CANCELLED, 4'd15, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: ;
                1: write_config(4'd3, 16'd750, 16'd250, 12'd20, 12'd10);
                2: write_config(4'd15, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
                3: write_config(4'd0, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
                4: write_config(4'd2, 16'd0, 16'd0, 12'd0, 12'd0);
                5: write_config(4'd4, 16'd1, 16'd1, 12'd1, 12'd1);
                6: write_config(4'd2, 16'd750, 16'd250, 12'd20, 12'd10);
                default: write_config(4'($urandom_range(0, 15)), 16'($urandom),
                                      16'($urandom), 12'($urandom), 12'($urandom));
            endcase
            need      = taps_needed;
            target    = (need == 4'd0) ? 16 : int'(need);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(noise_item());
                end else begin
                    send_tap_chain(($urandom_range(0, 1) != 0) ? target
                                                               : $urandom_range(1, target + 1),
                                   $urandom_range(0, 9) < 6);
                end
            end
        end

        settle(10);
        $display("Sent %0d touch events under %0d settings; checked %0d results, %0d gestures.",
                 items_sent, settings_run, results_seen, gestures);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches found", errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
